>>> rtl/current_sensor_fault_monitor_top_macros.svh
// Assertion helpers for the checker file.
`ifndef CURRENT_SENSOR_FAULT_MONITOR_TOP_MACROS_SVH
`define CURRENT_SENSOR_FAULT_MONITOR_TOP_MACROS_SVH

// Same-cycle implication, reset masks the check.
`define CSFM_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masks the check.
`define CSFM_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/csfm_pkg.sv
`timescale 1ns / 1ps

package csfm_pkg;

  // Fixed field widths
  localparam int RAW_W      = 12;
  localparam int ADC_W      = 12;
  localparam int TRANS_W    = 13;
  localparam int AMP_W      = 10;
  localparam int FAULT_W    = 7;
  localparam int WARN_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  typedef enum logic {
    OP_SAMPLE  = 1'b0,
    OP_TIMEOUT = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHORT_GND  = 3'd0,
    CFG_MIN_VALID  = 3'd1,
    CFG_SHORT_REF  = 3'd2,
    CFG_MAX_VALID  = 3'd3,
    CFG_TRANS_MIN  = 3'd4,
    CFG_TRANS_MAX  = 3'd5,
    CFG_WARN_CURR  = 3'd6,
    CFG_FAULT_CURR = 3'd7
  } cfg_idx_e;

  // Fault bit positions
  localparam int FLT_GND  = 0;
  localparam int FLT_OPEN = 1;
  localparam int FLT_REF  = 2;
  localparam int FLT_OC   = 3;
  localparam int FLT_SEV  = 4;
  localparam int FLT_IMPL = 5;
  localparam int FLT_TMO  = 6;

  // Warning bit positions
  localparam int WARN_OC  = 0;
  localparam int WARN_TMO = 1;

  localparam logic [FAULT_W-1:0] INVALID_MASK  = 7'h67;
  localparam logic [FAULT_W-1:0] TMO_FAULTS    = 7'h40;
  localparam logic [WARN_W-1:0]  TMO_WARNINGS  = 2'b10;

  localparam int IMPLAUSIBLE_A = 600;

  // Register reset values
  localparam logic [ADC_W-1:0]   RST_SHORT_GND  = 12'd50;
  localparam logic [ADC_W-1:0]   RST_MIN_VALID  = 12'd200;
  localparam logic [ADC_W-1:0]   RST_SHORT_REF  = 12'd3250;
  localparam logic [ADC_W-1:0]   RST_MAX_VALID  = 12'd3200;
  localparam logic [TRANS_W-1:0] RST_TRANS_MIN  = 13'd300;
  localparam logic [TRANS_W-1:0] RST_TRANS_MAX  = 13'd4800;
  localparam logic [AMP_W-1:0]   RST_WARN_CURR  = 10'd150;
  localparam logic [AMP_W-1:0]   RST_FAULT_CURR = 10'd200;

endpackage

>>> rtl/csfm_if.sv
`timescale 1ns / 1ps

interface csfm_in_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [csfm_pkg::RAW_W-1:0] raw_sample;

  modport source (output valid, output operation, output raw_sample, input ready);
  modport sink (input valid, input operation, input raw_sample, output ready);
endinterface

interface csfm_out_if;
  logic                         valid;
  logic                         ready;
  logic [csfm_pkg::ADC_W-1:0]   adc_mv;
  logic [csfm_pkg::TRANS_W-1:0] transducer_mv;
  logic [csfm_pkg::AMP_W-1:0]   current_a;
  logic [csfm_pkg::FAULT_W-1:0] faults;
  logic [csfm_pkg::WARN_W-1:0]  warnings;
  logic                         valid_res;

  modport source (output valid, output adc_mv, output transducer_mv, output current_a,
                  output faults, output warnings, output valid_res, input ready);
  modport sink (input valid, input adc_mv, input transducer_mv, input current_a,
                input faults, input warnings, input valid_res, output ready);
endinterface

>>> rtl/csfm_cdiv.sv
`timescale 1ns / 1ps

// Pipelined divide by a constant: reciprocal multiply, multiply back,
// one-step correction. Two register levels; quotient is combinational
// from the second. Requires num < 2^NUM_W and quotient < 2^Q_W.
module csfm_cdiv #(
  parameter int              NUM_W   = 25,
  parameter int              Q_W     = 12,
  parameter longint unsigned DIVISOR = 8190
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  output logic [Q_W-1:0]   quo_o
);

  localparam longint unsigned RECIP  = (64'd1 << NUM_W) / DIVISOR;
  localparam int              RCP_W  = $clog2(RECIP + 2);
  localparam int              DIV_W  = $clog2(DIVISOR + 1);
  localparam int              PROD_W = NUM_W + ((RCP_W > Q_W) ? RCP_W : Q_W);
  localparam int              BACK_W = Q_W + DIV_W;
  localparam int              CMP_W  = (NUM_W > BACK_W) ? NUM_W : BACK_W;

  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]    q0_q, q0b_q;
  logic [NUM_W-1:0]  numa_q, numb_q;
  logic [BACK_W-1:0] back_q;
  logic [CMP_W-1:0]  rem;

  // estimate is low by at most one
  assign prod = PROD_W'(num_i) * PROD_W'(RECIP);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q0_q   <= prod[NUM_W +: Q_W];
      numa_q <= num_i;
      back_q <= BACK_W'(q0_q) * BACK_W'(DIVISOR);
      q0b_q  <= q0_q;
      numb_q <= numa_q;
    end
  end

  assign rem   = CMP_W'(numb_q) - CMP_W'(back_q);
  assign quo_o = q0b_q + Q_W'(rem >= CMP_W'(DIVISOR));

endmodule

>>> rtl/current_sensor_fault_monitor_top.sv
`timescale 1ns / 1ps

// Current sensor fault monitor.
// Input channel in_i: one word per ADC conversion (operation = sample) or
// per conversion timeout (operation = timeout, raw_sample ignored).
// Output channel out_o: one result word per input word, in order: pin mV,
// transducer mV, whole amperes, fault bits, warning bits and a valid flag.
// Thresholds live in eight registers written through cfg_we_i/cfg_idx_i/
// cfg_wdata_i; write them only while no word is in flight.
// Throughput: one word per cycle while out_o is not stalled, set by the
// ten-level pipeline (three constant dividers built from reciprocal
// multiplies, each two multiplier levels deep).
// When out_o stalls, the whole pipeline freezes and in_i.ready drops in
// the same cycle; nothing is dropped or repeated. Bubbles are not squeezed.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the
// register defaults; no sweep is needed after release.
module current_sensor_fault_monitor_top #(
  parameter int ADC_BITS         = 12,
  parameter int REF_HI_MV        = 3300,
  parameter int REF_LO_MV        = 0,
  parameter int DIV_TOP_OHMS     = 10000,
  parameter int DIV_BOTTOM_OHMS  = 20000,
  parameter int SEVERE_CURRENT_A = 400
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  csfm_in_if.sink                          in_i,
  csfm_out_if.source                       out_o,
  input  logic                             cfg_we_i,
  input  logic [csfm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [csfm_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int RAW_W   = csfm_pkg::RAW_W;
  localparam int ADC_W   = csfm_pkg::ADC_W;
  localparam int TRANS_W = csfm_pkg::TRANS_W;
  localparam int AMP_W   = csfm_pkg::AMP_W;

  // ADC scaling: mV = (cnt*span*2 + full) / (2*full) + lo
  localparam longint unsigned FULL    = (64'd1 << ADC_BITS) - 64'd1;
  localparam longint unsigned RAW_MAX = (64'd1 << RAW_W) - 64'd1;
  localparam longint unsigned CNT_MAX = (FULL < RAW_MAX) ? FULL : RAW_MAX;
  localparam longint unsigned SPAN    = (REF_HI_MV >= REF_LO_MV) ?
                                        64'(REF_HI_MV - REF_LO_MV) : 64'd0;
  localparam longint unsigned P_MAX   = CNT_MAX * 64'd2 * SPAN + FULL;
  localparam int              P_W     = $clog2(P_MAX + 64'd1);
  localparam longint unsigned ADC_DIV = 64'd2 * FULL;
  localparam int              ADCQ_W  = $clog2(SPAN + 64'd2);

  // Divider: trans = adc*total/bot
  localparam longint unsigned BOT   = (DIV_BOTTOM_OHMS == 0) ? 64'd1 : 64'(DIV_BOTTOM_OHMS);
  localparam longint unsigned TOTAL = 64'(DIV_TOP_OHMS) + 64'(DIV_BOTTOM_OHMS);
  localparam int              TOT_W = $clog2(TOTAL + 64'd1);
  localparam int              N1_W  = ADC_W + TOT_W;
  localparam int              N4_W  = N1_W + 2;

  // 160 A/V around a 2.5 V reference: amps = (4*adc*total - 10000*bot) / (25*bot)
  localparam longint unsigned OFFS    = 64'd10000 * BOT;
  localparam longint unsigned AMP_DIV = 64'd25 * BOT;

  // Saturation limits carry one extra bit so comparisons see the overflow
  localparam longint unsigned TRANS_LIM = BOT << TRANS_W;
  localparam longint unsigned AMP_LIM   = AMP_DIV << AMP_W;
  localparam int              NT_W      = $clog2(TRANS_LIM);
  localparam int              NA_W      = $clog2(AMP_LIM);

  typedef struct packed {
    logic ovf_t;
    logic ovf_a;
    logic pos;
  } flag_t;

  // ------------------------------------------------------------------
  // Threshold registers
  // ------------------------------------------------------------------
  logic [ADC_W-1:0]   short_gnd_q, min_valid_q, short_ref_q, max_valid_q;
  logic [TRANS_W-1:0] trans_min_q, trans_max_q;
  logic [AMP_W-1:0]   warn_curr_q, fault_curr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_gnd_q  <= csfm_pkg::RST_SHORT_GND;
      min_valid_q  <= csfm_pkg::RST_MIN_VALID;
      short_ref_q  <= csfm_pkg::RST_SHORT_REF;
      max_valid_q  <= csfm_pkg::RST_MAX_VALID;
      trans_min_q  <= csfm_pkg::RST_TRANS_MIN;
      trans_max_q  <= csfm_pkg::RST_TRANS_MAX;
      warn_curr_q  <= csfm_pkg::RST_WARN_CURR;
      fault_curr_q <= csfm_pkg::RST_FAULT_CURR;
    end else if (cfg_we_i) begin
      unique case (csfm_pkg::cfg_idx_e'(cfg_idx_i))
        csfm_pkg::CFG_SHORT_GND:  short_gnd_q  <= cfg_wdata_i[ADC_W-1:0];
        csfm_pkg::CFG_MIN_VALID:  min_valid_q  <= cfg_wdata_i[ADC_W-1:0];
        csfm_pkg::CFG_SHORT_REF:  short_ref_q  <= cfg_wdata_i[ADC_W-1:0];
        csfm_pkg::CFG_MAX_VALID:  max_valid_q  <= cfg_wdata_i[ADC_W-1:0];
        csfm_pkg::CFG_TRANS_MIN:  trans_min_q  <= cfg_wdata_i[TRANS_W-1:0];
        csfm_pkg::CFG_TRANS_MAX:  trans_max_q  <= cfg_wdata_i[TRANS_W-1:0];
        csfm_pkg::CFG_WARN_CURR:  warn_curr_q  <= cfg_wdata_i[AMP_W-1:0];
        csfm_pkg::CFG_FAULT_CURR: fault_curr_q <= cfg_wdata_i[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Pipeline control: every level moves together; a stalled output
  // freezes the lot.
  // ------------------------------------------------------------------
  logic       en;
  logic [9:1] vld_q;
  logic       out_vld_q;

  assign en        = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[8:1], in_i.valid};
      out_vld_q <= vld_q[9];
    end
  end

  // operation code rides alongside the data
  logic [9:1] op_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      op_q <= {op_q[8:1], in_i.operation};
    end
  end

  // ------------------------------------------------------------------
  // Level 1: clamp and scale numerator
  // ------------------------------------------------------------------
  logic [RAW_W-1:0] cnt;
  logic [P_W-1:0]   p_d, p_q;

  assign cnt = (64'(in_i.raw_sample) > FULL) ? RAW_W'(FULL) : in_i.raw_sample;
  assign p_d = P_W'(cnt) * P_W'(64'd2 * SPAN) + P_W'(FULL);

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q <= p_d;
    end
  end

  // ------------------------------------------------------------------
  // Levels 2-3: rounded divide to pin millivolts, level 4 adds offset
  // ------------------------------------------------------------------
  logic [ADCQ_W-1:0] adc_quo;
  logic [ADC_W-1:0]  adc_q [4:9];

  csfm_cdiv #(
    .NUM_W   (P_W),
    .Q_W     (ADCQ_W),
    .DIVISOR (ADC_DIV)
  ) u_div_adc (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (p_q),
    .quo_o (adc_quo)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      adc_q[4] <= ADC_W'(adc_quo) + ADC_W'(REF_LO_MV);
      for (int i = 5; i <= 9; i++) begin
        adc_q[i] <= adc_q[i-1];
      end
    end
  end

  // ------------------------------------------------------------------
  // Level 5: scale through the divider ratio
  // ------------------------------------------------------------------
  logic [N1_W-1:0] n1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      n1_q <= N1_W'(adc_q[4]) * N1_W'(TOTAL);
    end
  end

  // ------------------------------------------------------------------
  // Level 6: offset, sign and overflow detection, clamp the numerators
  // ------------------------------------------------------------------
  logic [N4_W-1:0] n4;
  logic [N4_W-1:0] amp_num;
  flag_t           flg_d;
  flag_t           flg_q [6:8];
  logic [NT_W-1:0] nt_q;
  logic [NA_W-1:0] na_q;

  assign n4          = {n1_q, 2'b00};
  assign amp_num     = N4_W'(64'(n4) - OFFS);
  assign flg_d.pos   = 64'(n4) > OFFS;
  assign flg_d.ovf_t = 64'(n1_q) >= TRANS_LIM;
  assign flg_d.ovf_a = 64'(amp_num) >= AMP_LIM;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nt_q     <= flg_d.ovf_t ? NT_W'(TRANS_LIM - 64'd1) : NT_W'(n1_q);
      na_q     <= flg_d.ovf_a ? NA_W'(AMP_LIM - 64'd1) : NA_W'(amp_num);
      flg_q[6] <= flg_d;
      flg_q[7] <= flg_q[6];
      flg_q[8] <= flg_q[7];
    end
  end

  // ------------------------------------------------------------------
  // Levels 7-8: transducer mV and amperes dividers in parallel
  // ------------------------------------------------------------------
  logic [TRANS_W-1:0] trans_quo;
  logic [AMP_W-1:0]   amp_quo;

  csfm_cdiv #(
    .NUM_W   (NT_W),
    .Q_W     (TRANS_W),
    .DIVISOR (BOT)
  ) u_div_trans (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (nt_q),
    .quo_o (trans_quo)
  );

  csfm_cdiv #(
    .NUM_W   (NA_W),
    .Q_W     (AMP_W),
    .DIVISOR (AMP_DIV)
  ) u_div_amp (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (na_q),
    .quo_o (amp_quo)
  );

  // ------------------------------------------------------------------
  // Level 9: apply overflow and negative-current clamps (one spare bit)
  // ------------------------------------------------------------------
  logic [TRANS_W:0] trans_q;
  logic [AMP_W:0]   amps_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      trans_q <= flg_q[8].ovf_t ? (TRANS_W+1)'(TRANS_LIM / BOT) : (TRANS_W+1)'(trans_quo);
      if (!flg_q[8].pos) begin
        amps_q <= '0;
      end else if (flg_q[8].ovf_a) begin
        amps_q <= (AMP_W+1)'(AMP_LIM / AMP_DIV);
      end else begin
        amps_q <= (AMP_W+1)'(amp_quo);
      end
    end
  end

  // ------------------------------------------------------------------
  // Level 10: threshold checks into the output register
  // ------------------------------------------------------------------
  logic [ADC_W-1:0]             adc9;
  logic [csfm_pkg::FAULT_W-1:0] flt;
  logic [csfm_pkg::WARN_W-1:0]  wrn;
  logic                         amp_gt_fault;
  logic [ADC_W-1:0]             adc_mv_q;
  logic [TRANS_W-1:0]           trans_mv_q;
  logic [AMP_W-1:0]             current_q;
  logic [csfm_pkg::FAULT_W-1:0] faults_q;
  logic [csfm_pkg::WARN_W-1:0]  warnings_q;
  logic                         valid_res_q;

  assign adc9         = adc_q[9];
  assign amp_gt_fault = amps_q > (AMP_W+1)'(fault_curr_q);

  always_comb begin
    flt = '0;
    wrn = '0;
    flt[csfm_pkg::FLT_GND]  = adc9 <= short_gnd_q;
    flt[csfm_pkg::FLT_OPEN] = (adc9 < min_valid_q) ||
                              (trans_q < (TRANS_W+1)'(trans_min_q));
    flt[csfm_pkg::FLT_REF]  = (adc9 >= short_ref_q) || (adc9 > max_valid_q) ||
                              (trans_q > (TRANS_W+1)'(trans_max_q));
    flt[csfm_pkg::FLT_OC]   = amp_gt_fault;
    flt[csfm_pkg::FLT_SEV]  = amps_q > (AMP_W+1)'(SEVERE_CURRENT_A);
    flt[csfm_pkg::FLT_IMPL] = amps_q > (AMP_W+1)'(csfm_pkg::IMPLAUSIBLE_A);
    wrn[csfm_pkg::WARN_OC]  = (amps_q > (AMP_W+1)'(warn_curr_q)) && !amp_gt_fault;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (op_q[9] == csfm_pkg::OP_TIMEOUT) begin
        adc_mv_q    <= '0;
        trans_mv_q  <= '0;
        current_q   <= '0;
        faults_q    <= csfm_pkg::TMO_FAULTS;
        warnings_q  <= csfm_pkg::TMO_WARNINGS;
        valid_res_q <= 1'b0;
      end else begin
        adc_mv_q    <= adc9;
        trans_mv_q  <= trans_q[TRANS_W] ? '1 : trans_q[TRANS_W-1:0];
        current_q   <= amps_q[AMP_W] ? '1 : amps_q[AMP_W-1:0];
        faults_q    <= flt;
        warnings_q  <= wrn;
        valid_res_q <= (flt & csfm_pkg::INVALID_MASK) == '0;
      end
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.adc_mv        = adc_mv_q;
  assign out_o.transducer_mv = trans_mv_q;
  assign out_o.current_a     = current_q;
  assign out_o.faults        = faults_q;
  assign out_o.warnings      = warnings_q;
  assign out_o.valid_res     = valid_res_q;

endmodule

>>> rtl/csfm_checker.sv
`timescale 1ns / 1ps

`include "current_sensor_fault_monitor_top_macros.svh"

module csfm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [csfm_pkg::ADC_W-1:0]   adc_mv_i,
  input logic [csfm_pkg::TRANS_W-1:0] transducer_mv_i,
  input logic [csfm_pkg::AMP_W-1:0]   current_a_i,
  input logic [csfm_pkg::FAULT_W-1:0] faults_i,
  input logic [csfm_pkg::WARN_W-1:0]  warnings_i,
  input logic                         valid_res_i
);

  // a timeout word carries nothing but its own fault and warning
  `CSFM_ASSERT_IMP(a_tmo_word, clk_i, rst_ni, out_valid_i && faults_i[csfm_pkg::FLT_TMO], adc_mv_i == '0 && transducer_mv_i == '0 && current_a_i == '0 && faults_i == csfm_pkg::TMO_FAULTS && warnings_i == csfm_pkg::TMO_WARNINGS && !valid_res_i, "timeout word carries data")

  `CSFM_ASSERT_IMP(a_valid_flag, clk_i, rst_ni, out_valid_i, valid_res_i == ((faults_i & csfm_pkg::INVALID_MASK) == '0), "valid flag disagrees with faults")

  `CSFM_ASSERT_IMP(a_oc_excl, clk_i, rst_ni, out_valid_i, !(warnings_i[csfm_pkg::WARN_OC] && faults_i[csfm_pkg::FLT_OC]), "overcurrent warning and fault together")

  `CSFM_ASSERT_NXT(a_stall_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(faults_i) && $stable(current_a_i) && $stable(adc_mv_i), "stalled word changed")

endmodule

bind current_sensor_fault_monitor_top csfm_checker u_csfm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .adc_mv_i        (out_o.adc_mv),
  .transducer_mv_i (out_o.transducer_mv),
  .current_a_i     (out_o.current_a),
  .faults_i        (out_o.faults),
  .warnings_i      (out_o.warnings),
  .valid_res_i     (out_o.valid_res)
);

>>> tb/current_sensor_fault_monitor_check.sv
`timescale 1ns / 1ps

module current_sensor_fault_monitor_check
  import csfm_pkg::*;
#(
  parameter int ADC_BITS         = 12,
  parameter int REF_HI_MV        = 3300,
  parameter int REF_LO_MV        = 0,
  parameter int DIV_TOP_OHMS     = 10000,
  parameter int DIV_BOTTOM_OHMS  = 20000,
  parameter int SEVERE_CURRENT_A = 400
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  csfm_in_if                    in_mon_i,
  csfm_out_if                   out_mon_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    mismatches_o,
  output int                    pending_o
);

  typedef longint unsigned u64_t;

  typedef struct {
    logic [ADC_W-1:0]   adc_mv;
    logic [TRANS_W-1:0] transducer_mv;
    logic [AMP_W-1:0]   current_a;
    logic [FAULT_W-1:0] faults;
    logic [WARN_W-1:0]  warnings;
    logic               valid_res;
  } reading_t;

  // Threshold copy, tracked from the write port
  logic [ADC_W-1:0]   gnd_lim, open_lim, ref_lim, high_lim;
  logic [TRANS_W-1:0] trans_low_lim, trans_high_lim;
  logic [AMP_W-1:0]   warn_lim, fault_lim;

  reading_t expected_readings [$];
  reading_t want;
  int       errors;

  function automatic reading_t predict_reading(op_e op, logic [RAW_W-1:0] raw);
    reading_t r;
    u64_t     full, counts, span, mv, bot, total, trans, amps, num, offs;
    r = '{default: '0};
    if (op == OP_TIMEOUT) begin
      r.faults   = TMO_FAULTS;
      r.warnings = TMO_WARNINGS;
      return r;
    end
    full = (u64_t'(1) << ADC_BITS) - 1;
    if (full == 0) full = 1;
    counts = u64_t'(raw);
    if (counts > full) counts = full;
    span = (REF_HI_MV >= REF_LO_MV) ? u64_t'(REF_HI_MV - REF_LO_MV) : 0;
    mv   = (counts * span * 2 + full) / (2 * full) + u64_t'(REF_LO_MV);
    bot   = (DIV_BOTTOM_OHMS != 0) ? u64_t'(DIV_BOTTOM_OHMS) : 1;
    total = u64_t'(DIV_TOP_OHMS) + u64_t'(DIV_BOTTOM_OHMS);
    trans = mv * total / bot;
    // 160 A/V around a 2.5 V midpoint, floor, negative clamps to zero
    num  = 4 * mv * total;
    offs = 10000 * bot;
    amps = (num > offs) ? (num - offs) / (25 * bot) : 0;

    r.faults[FLT_GND]  = (mv <= gnd_lim);
    r.faults[FLT_OPEN] = (mv < open_lim) || (trans < trans_low_lim);
    r.faults[FLT_REF]  = (mv >= ref_lim) || (mv > high_lim) || (trans > trans_high_lim);
    r.faults[FLT_OC]   = (amps > fault_lim);
    r.faults[FLT_SEV]  = (amps > u64_t'(SEVERE_CURRENT_A));
    r.faults[FLT_IMPL] = (amps > u64_t'(IMPLAUSIBLE_A));
    r.warnings[WARN_OC] = (amps > warn_lim) && (amps <= fault_lim);
    r.valid_res = ((r.faults & INVALID_MASK) == '0);

    r.adc_mv        = (mv > u64_t'({ADC_W{1'b1}})) ? '1 : mv[ADC_W-1:0];
    r.transducer_mv = (trans > u64_t'({TRANS_W{1'b1}})) ? '1 : trans[TRANS_W-1:0];
    r.current_a     = (amps > u64_t'({AMP_W{1'b1}})) ? '1 : amps[AMP_W-1:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
    if (act_val !== exp_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gnd_lim        = RST_SHORT_GND;
      open_lim       = RST_MIN_VALID;
      ref_lim        = RST_SHORT_REF;
      high_lim       = RST_MAX_VALID;
      trans_low_lim  = RST_TRANS_MIN;
      trans_high_lim = RST_TRANS_MAX;
      warn_lim       = RST_WARN_CURR;
      fault_lim      = RST_FAULT_CURR;
      expected_readings.delete();
      errors = 0;
      pending_o    <= 0;
      mismatches_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SHORT_GND:  gnd_lim        = cfg_wdata_i[ADC_W-1:0];
          CFG_MIN_VALID:  open_lim       = cfg_wdata_i[ADC_W-1:0];
          CFG_SHORT_REF:  ref_lim        = cfg_wdata_i[ADC_W-1:0];
          CFG_MAX_VALID:  high_lim       = cfg_wdata_i[ADC_W-1:0];
          CFG_TRANS_MIN:  trans_low_lim  = cfg_wdata_i[TRANS_W-1:0];
          CFG_TRANS_MAX:  trans_high_lim = cfg_wdata_i[TRANS_W-1:0];
          CFG_WARN_CURR:  warn_lim       = cfg_wdata_i[AMP_W-1:0];
          CFG_FAULT_CURR: fault_lim      = cfg_wdata_i[AMP_W-1:0];
          default: ;
        endcase
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (expected_readings.size() == 0) begin
          errors++;
          $display("%0t: result word with none expected, expected nothing, actual adc_mv %0d",
                   $time, out_mon_i.adc_mv);
        end else begin
          want = expected_readings.pop_front();
          check_field("adc_mv", want.adc_mv, out_mon_i.adc_mv);
          check_field("transducer_mv", want.transducer_mv, out_mon_i.transducer_mv);
          check_field("current_a", want.current_a, out_mon_i.current_a);
          check_field("faults", want.faults, out_mon_i.faults);
          check_field("warnings", want.warnings, out_mon_i.warnings);
          check_field("valid_res", want.valid_res, out_mon_i.valid_res);
        end
      end
      if (in_mon_i.valid && in_mon_i.ready)
        expected_readings.push_back(predict_reading(op_e'(in_mon_i.operation),
                                                    in_mon_i.raw_sample));
      pending_o    <= expected_readings.size();
      mismatches_o <= errors;
    end
  end

endmodule

>>> tb/current_sensor_fault_monitor_top_test.sv
`timescale 1ns / 1ps

// Stimulus and verdict. The checker beside the block does all prediction.
module current_sensor_fault_monitor_top_test;
  import csfm_pkg::*;

  // Build constants, same values on the block and on the checker
  localparam int ADC_BITS         = 12;
  localparam int REF_HI_MV        = 3300;
  localparam int REF_LO_MV        = 0;
  localparam int DIV_TOP_OHMS     = 10000;
  localparam int DIV_BOTTOM_OHMS  = 20000;
  localparam int SEVERE_CURRENT_A = 400;

  localparam int TX_GAP_MAX      = 17;
  localparam int RX_STALL_MAX    = 17;
  localparam int PHASES          = 10;
  localparam int WORDS_PER_PHASE = 193;
  localparam int HOLD_OFF_AT     = 700;   // result count at which the sink goes quiet
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 12;
  localparam int RUN_LIMIT_NS    = 10_000_000;

  // Raw counts around the default thresholds: rails, gnd short, open, ref short,
  // high limit, zero-current point, warning and fault currents, bit patterns.
  localparam logic [RAW_W-1:0] DIRECTED_RAW [19] = '{
    12'd0, 12'd1, 12'd62, 12'd63, 12'd247, 12'd248, 12'd3971, 12'd3972,
    12'd4033, 12'd4034, 12'd4094, 12'd4095, 12'd2068, 12'd2069, 12'd2843,
    12'd3102, 12'd3103, 12'hAAA, 12'h555
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  int                    mismatches;
  int                    pending;

  // Threshold values as last written, indexed by register
  logic [CFG_DATA_W-1:0] limits [8];

  csfm_in_if  in_if ();
  csfm_out_if out_if ();

  current_sensor_fault_monitor_top #(
    .ADC_BITS        (ADC_BITS),
    .REF_HI_MV       (REF_HI_MV),
    .REF_LO_MV       (REF_LO_MV),
    .DIV_TOP_OHMS    (DIV_TOP_OHMS),
    .DIV_BOTTOM_OHMS (DIV_BOTTOM_OHMS),
    .SEVERE_CURRENT_A(SEVERE_CURRENT_A)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  current_sensor_fault_monitor_check #(
    .ADC_BITS        (ADC_BITS),
    .REF_HI_MV       (REF_HI_MV),
    .REF_LO_MV       (REF_LO_MV),
    .DIV_TOP_OHMS    (DIV_TOP_OHMS),
    .DIV_BOTTOM_OHMS (DIV_BOTTOM_OHMS),
    .SEVERE_CURRENT_A(SEVERE_CURRENT_A)
  ) u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon_i    (in_if),
    .out_mon_i   (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

  // Largest value the register holds
  function automatic int limit_ceiling(cfg_idx_e idx);
    case (idx)
      CFG_TRANS_MIN, CFG_TRANS_MAX:  return (1 << TRANS_W) - 1;
      CFG_WARN_CURR, CFG_FAULT_CURR: return (1 << AMP_W) - 1;
      default:                       return (1 << ADC_W) - 1;
    endcase
  endfunction

  // Bound just above the largest value the sample path reaches for each quantity:
  // 3300 mV at the pin, 4950 mV at the transducer, 392 A.
  function automatic int limit_reach(cfg_idx_e idx);
    case (idx)
      CFG_TRANS_MIN, CFG_TRANS_MAX:  return 5000;
      CFG_WARN_CURR, CFG_FAULT_CURR: return 400;
      default:                       return 3320;
    endcase
  endfunction

  // Raw counts that land a few mV around one of the current thresholds
  function automatic logic [RAW_W-1:0] raw_near_limit();
    cfg_idx_e idx;
    int       lim, mv, raw;
    idx = cfg_idx_e'($urandom_range(0, 7));
    lim = int'(limits[idx]) & limit_ceiling(idx);
    case (idx)
      CFG_TRANS_MIN, CFG_TRANS_MAX:  mv = lim * 2 / 3;
      CFG_WARN_CURR, CFG_FAULT_CURR: mv = (lim * 500000 + 200000000) / 120000;
      default:                       mv = lim;
    endcase
    raw = (mv * 4095 + 1650) / 3300 + $urandom_range(0, 4) - 2;
    if (raw < 0) raw = 0;
    if (raw > 4095) raw = 4095;
    return raw[RAW_W-1:0];
  endfunction

  // Offer one word after a random gap; returns once it is taken.
  // Valid stays high afterwards so back-to-back words need no second assignment.
  task automatic send_word(op_e op, logic [RAW_W-1:0] raw, int gap_max);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.operation  <= op;
    in_if.raw_sample <= raw;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_random_word(int n);
    int          pick, gap_max;
    logic [RAW_W-1:0] raw;
    // stretches with no gaps at all, then stretches with random gaps
    gap_max = ((n % 96) < 24) ? 0 : TX_GAP_MAX;
    pick = $urandom_range(0, 99);
    raw  = $urandom_range(0, 4095);
    if (pick < 10)
      send_word(OP_TIMEOUT, raw, gap_max);
    else if (pick < 40)
      send_word(OP_SAMPLE, raw_near_limit(), gap_max);
    else if (pick < 45)
      send_word(OP_SAMPLE, ($urandom_range(0, 1) != 0) ? '1 : '0, gap_max);
    else
      send_word(OP_SAMPLE, raw, gap_max);
  endtask

  // Stop offering and wait until every result word has come back
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // All eight registers, back to back with the enable held high
  task automatic load_limits();
    cfg_idx_e idx;
    idx = idx.first();
    do begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx;
      cfg_wdata_i <= limits[idx];
      @(posedge clk_i);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_we_i <= 1'b0;
  endtask

  // Phase 1: all zero. Phase 2: all ones on the full write width, so the
  // narrower registers see their upper bits dropped. Later: random, mostly
  // inside the reachable range, sometimes anywhere in the 13-bit write word.
  task automatic pick_limits(int phase);
    cfg_idx_e idx;
    idx = idx.first();
    do begin
      if (phase == 1)
        limits[idx] = '0;
      else if (phase == 2)
        limits[idx] = '1;
      else if ($urandom_range(0, 3) == 0)
        limits[idx] = $urandom_range(0, (1 << CFG_DATA_W) - 1);
      else
        limits[idx] = $urandom_range(0, limit_reach(idx));
      idx = idx.next();
    end while (idx != idx.first());
  endtask

  // Sink side: random stalls, stretches of full speed, one long hold-off
  // that backs the pipeline up into the input.
  initial begin
    int stall;
    int taken;
    taken = 0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (taken == HOLD_OFF_AT)
        stall = HOLD_OFF_CYCLES;
      else
        stall = ((taken % 70) < 15) ? 0 : $urandom_range(0, RX_STALL_MAX);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      taken++;
    end
  end

  // Source side and verdict
  initial begin
    int n;
    in_if.valid      <= 1'b0;
    in_if.operation  <= OP_SAMPLE;
    in_if.raw_sample <= '0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= CFG_SHORT_GND;
    cfg_wdata_i      <= '0;
    rst_ni           <= 1'b0;
    limits[CFG_SHORT_GND]  = RST_SHORT_GND;
    limits[CFG_MIN_VALID]  = RST_MIN_VALID;
    limits[CFG_SHORT_REF]  = RST_SHORT_REF;
    limits[CFG_MAX_VALID]  = RST_MAX_VALID;
    limits[CFG_TRANS_MIN]  = RST_TRANS_MIN;
    limits[CFG_TRANS_MAX]  = RST_TRANS_MAX;
    limits[CFG_WARN_CURR]  = RST_WARN_CURR;
    limits[CFG_FAULT_CURR] = RST_FAULT_CURR;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words under the reset thresholds, then timeouts with both
    // raw extremes (raw must be ignored).
    foreach (DIRECTED_RAW[k]) send_word(OP_SAMPLE, DIRECTED_RAW[k], TX_GAP_MAX);
    send_word(OP_TIMEOUT, '0, TX_GAP_MAX);
    send_word(OP_TIMEOUT, '1, 0);

    // Random words, a fresh threshold set per phase; phase 0 keeps the defaults
    n = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        drain();
        pick_limits(phase);
        load_limits();
      end
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        send_random_word(n);
        n++;
      end
    end
    drain();

    if (mismatches == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
